// ----- design/kft_pkg.sv -----
// Package: sizes, command and status codes, controller/datapath structs for the keyed FIFO table.
`default_nettype none
package kft_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SCAN_W = $clog2(DEPTH + 2);
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned OCC_W  = 5;

  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_HIT,
    RES_OK,
    RES_MISS,
    RES_FULL
  } res_sel_e;

  typedef struct packed {
    logic     capture;
    logic     step;
    logic     shift_wr;
    logic     upd_wr;
    logic     app_wr;
    logic     clr;
    logic     dec;
    logic     load_out;
    res_sel_e res_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              hit;
    logic              lag_vld;
    logic              idx_nz;
    logic              full;
    logic              out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- design/kft_if.sv -----
// Interfaces: command channel and response channel with valid/ready handshake.
`default_nettype none
interface kft_cmd_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  mode;
  logic signed [31:0] key;
  logic signed [31:0] item_value;

  modport source (output valid, output mode, output key, output item_value, input ready);
  modport sink   (input valid, input mode, input key, input item_value, output ready);
endinterface

interface kft_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] found_value;
  logic        [1:0]  status;
  logic        [4:0]  occupancy;

  modport source (output valid, output found_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input found_value, input status, input occupancy,
                  output ready);
endinterface
`default_nettype wire

// ----- design/kft_ctrl.sv -----
// Controller: sequences decode, key scan, gap-closing shift and response hand-off.
`default_nettype none
module kft_ctrl
  import kft_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cmd_valid_i,
  output logic           cmd_ready_o,
  input  wire dp_stat_t  stat_i,
  output ctrl_cmd_t      ctrl_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    cmd_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FINISH;
        case (stat_i.mode)
          MODE_APPEND: begin
            if (stat_i.full) begin
              ctrl_o.res_sel = RES_FULL;
            end else begin
              ctrl_o.app_wr  = 1'b1;
              ctrl_o.res_sel = RES_OK;
            end
          end
          MODE_REMOVE, MODE_LOOKUP, MODE_UPDATE: begin
            state_d = S_SCAN;
          end
          MODE_CLEAR: begin
            ctrl_o.clr     = 1'b1;
            ctrl_o.res_sel = RES_OK;
          end
          default: begin
            ctrl_o.res_sel = RES_OK;
          end
        endcase
      end
      S_SCAN: begin
        ctrl_o.step = 1'b1;
        if (stat_i.hit) begin
          case (stat_i.mode)
            MODE_REMOVE: begin
              ctrl_o.res_sel = RES_HIT;
              state_d        = S_SHIFT;
            end
            MODE_UPDATE: begin
              ctrl_o.upd_wr  = 1'b1;
              ctrl_o.res_sel = RES_OK;
              state_d        = S_FINISH;
            end
            default: begin
              ctrl_o.res_sel = RES_HIT;
              state_d        = S_FINISH;
            end
          endcase
        end else if (!stat_i.lag_vld && stat_i.idx_nz) begin
          ctrl_o.res_sel = RES_MISS;
          state_d        = S_FINISH;
        end
      end
      S_SHIFT: begin
        ctrl_o.step = 1'b1;
        if (stat_i.lag_vld) begin
          ctrl_o.shift_wr = 1'b1;
        end else begin
          ctrl_o.dec = 1'b1;
          state_d    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          ctrl_o.load_out = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/kft_dp.sv -----
// Datapath: key/value memories, fill count, scan pointers and response register.
`default_nettype none
module kft_dp
  import kft_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [MODE_W-1:0]  cmd_mode_i,
  input  wire logic [KEY_W-1:0]   cmd_key_i,
  input  wire logic [VAL_W-1:0]   cmd_value_i,
  input  wire ctrl_cmd_t          ctrl_i,
  output dp_stat_t                stat_o,
  input  wire logic               rsp_ready_i,
  output logic                    rsp_valid_o,
  output logic [VAL_W-1:0]        rsp_found_o,
  output logic [ST_W-1:0]         rsp_status_o,
  output logic [OCC_W-1:0]        rsp_occ_o
);

  logic [KEY_W-1:0]  keys_q [DEPTH];
  logic [VAL_W-1:0]  vals_q [DEPTH];

  logic [MODE_W-1:0] mode_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic [CNT_W-1:0]  count_q;
  logic [SCAN_W-1:0] idx_q;
  logic [IDX_W-1:0]  lag_q;
  logic              lag_vld_q;
  logic [KEY_W-1:0]  key_rd_q;
  logic [VAL_W-1:0]  val_rd_q;
  logic [VAL_W-1:0]  res_found_q;
  logic [ST_W-1:0]   res_status_q;
  logic              out_valid_q;
  logic [VAL_W-1:0]  out_found_q;
  logic [ST_W-1:0]   out_status_q;
  logic [OCC_W-1:0]  out_occ_q;

  logic              key_wr;
  logic              val_wr;
  logic [IDX_W-1:0]  wr_addr;
  logic [KEY_W-1:0]  key_wdata;
  logic [VAL_W-1:0]  val_wdata;
  logic [IDX_W-1:0]  rd_addr;

  assign rd_addr = idx_q[IDX_W-1:0];

  always_comb begin
    key_wr    = 1'b0;
    val_wr    = 1'b0;
    wr_addr   = lag_q;
    key_wdata = key_rd_q;
    val_wdata = val_rd_q;
    if (ctrl_i.app_wr) begin
      key_wr    = 1'b1;
      val_wr    = 1'b1;
      wr_addr   = count_q[IDX_W-1:0];
      key_wdata = key_q;
      val_wdata = val_q;
    end else if (ctrl_i.upd_wr) begin
      val_wr    = 1'b1;
      wr_addr   = lag_q;
      val_wdata = val_q;
    end else if (ctrl_i.shift_wr) begin
      key_wr  = 1'b1;
      val_wr  = 1'b1;
      wr_addr = lag_q - IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_wr) begin
      keys_q[wr_addr] <= key_wdata;
    end
    if (val_wr) begin
      vals_q[wr_addr] <= val_wdata;
    end
    key_rd_q <= keys_q[rd_addr];
    val_rd_q <= vals_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      mode_q <= cmd_mode_i;
      key_q  <= cmd_key_i;
      val_q  <= cmd_value_i;
    end
    lag_q <= idx_q[IDX_W-1:0];
    case (ctrl_i.res_sel)
      RES_HIT: begin
        res_found_q  <= val_rd_q;
        res_status_q <= ST_OK;
      end
      RES_OK: begin
        res_found_q  <= '0;
        res_status_q <= ST_OK;
      end
      RES_MISS: begin
        res_found_q  <= '0;
        res_status_q <= ST_MISSING;
      end
      RES_FULL: begin
        res_found_q  <= '0;
        res_status_q <= ST_FULL;
      end
      default: begin
      end
    endcase
    if (ctrl_i.load_out) begin
      out_found_q  <= res_found_q;
      out_status_q <= res_status_q;
      out_occ_q    <= OCC_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      lag_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.capture) begin
        idx_q <= '0;
      end else if (ctrl_i.step) begin
        idx_q <= idx_q + SCAN_W'(1);
      end
      lag_vld_q <= ctrl_i.step && (idx_q < SCAN_W'(count_q));
      if (ctrl_i.clr) begin
        count_q <= '0;
      end else if (ctrl_i.app_wr) begin
        count_q <= count_q + CNT_W'(1);
      end else if (ctrl_i.dec) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (ctrl_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.mode     = mode_q;
  assign stat_o.hit      = lag_vld_q && (key_rd_q == key_q);
  assign stat_o.lag_vld  = lag_vld_q;
  assign stat_o.idx_nz   = (idx_q != '0);
  assign stat_o.full     = (count_q >= CNT_W'(DEPTH));
  assign stat_o.out_free = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o  = out_valid_q;
  assign rsp_found_o  = out_found_q;
  assign rsp_status_o = out_status_q;
  assign rsp_occ_o    = out_occ_q;

endmodule
`default_nettype wire

// ----- design/keyed_fifo_table.sv -----
// Top level: keyed FIFO table, controller plus datapath behind command/response channels.
`default_nettype none
// Holds up to DEPTH key/value pairs in insertion order, duplicates allowed; remove, lookup
// and update act on the oldest entry whose key matches. One command beat in gives one
// response beat out. Commands are taken one at a time; append, clear and unused codes need
// no search. A search walks the entries through the single read port of the key memory at
// one entry per cycle, and remove then shifts each entry behind the match down by one to
// close the gap. The response sits in an output register, so the response side may stall
// while the next command is already running.
module keyed_fifo_table
  import kft_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  kft_cmd_if.sink    cmd_i,
  kft_rsp_if.source  rsp_o
);

  ctrl_cmd_t         ctrl;
  dp_stat_t          stat;
  logic [VAL_W-1:0]  found;

  kft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  kft_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_mode_i   (cmd_i.mode),
    .cmd_key_i    ($unsigned(cmd_i.key)),
    .cmd_value_i  ($unsigned(cmd_i.item_value)),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_found_o  (found),
    .rsp_status_o (rsp_o.status),
    .rsp_occ_o    (rsp_o.occupancy)
  );

  assign rsp_o.found_value = $signed(found);

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.occupancy <= OCC_W'(DEPTH)))
    else $error("occupancy above table depth");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == ST_FULL)) |-> (rsp_o.occupancy == OCC_W'(DEPTH)))
    else $error("full status while table not full");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> !cmd_i.ready)
    else $error("command taken while previous one in flight");

  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != ST_OK)) |-> (rsp_o.found_value == '0))
    else $error("nonzero value on failed command");

endmodule
`default_nettype wire

// ----- tb/sv/keyed_fifo_table_tb.sv -----
// Testbench for keyed_fifo_table: random handshake traffic checked against a behavioral table.
`timescale 1ns / 100ps

module keyed_fifo_table_tb;
  import kft_pkg::*;

  localparam int unsigned N_ITEMS    = 550;
  localparam int unsigned N_POOL     = 6;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned LONG_HOLD  = 160;
  localparam int unsigned HOLD_AT    = 250;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] item_value;
  } cmd_beat_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] found_value;
    logic [ST_W-1:0]         status;
    logic [OCC_W-1:0]        occupancy;
  } rsp_beat_t;

  logic clk;
  logic rst_n;

  kft_cmd_if cmd_bus ();
  kft_rsp_if rsp_bus ();

  keyed_fifo_table DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_bus),
    .rsp_o  (rsp_bus)
  );

  cmd_beat_t cmd_q[$];
  rsp_beat_t expected_rsp_q[$];

  logic [KEY_W-1:0] ledger_key[DEPTH];
  logic [VAL_W-1:0] ledger_val[DEPTH];
  int               ledger_fill;

  logic [KEY_W-1:0] key_pool[N_POOL];

  int    err_count;
  int    tx_gap;
  bit    tx_burst;
  int    rx_stall;
  bit    rx_burst;
  bit    hold_done;
  int    rsp_count;
  int    idle_cycles;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic rsp_beat_t ledger_apply(cmd_beat_t c);
    rsp_beat_t r;
    int        pos;
    r.found_value = '0;
    r.status      = ST_OK;
    pos           = -1;
    for (int i = 0; i < ledger_fill; i++) begin
      if (pos < 0 && ledger_key[i] == c.key) pos = i;
    end
    case (c.mode)
      MODE_APPEND: begin
        if (ledger_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ledger_key[ledger_fill] = c.key;
          ledger_val[ledger_fill] = c.item_value;
          ledger_fill++;
        end
      end
      MODE_REMOVE: begin
        if (pos < 0) begin
          r.status = ST_MISSING;
        end else begin
          r.found_value = ledger_val[pos];
          for (int i = pos; i < ledger_fill - 1; i++) begin
            ledger_key[i] = ledger_key[i + 1];
            ledger_val[i] = ledger_val[i + 1];
          end
          ledger_fill--;
        end
      end
      MODE_LOOKUP: begin
        if (pos < 0) r.status = ST_MISSING;
        else r.found_value = ledger_val[pos];
      end
      MODE_UPDATE: begin
        if (pos < 0) r.status = ST_MISSING;
        else ledger_val[pos] = c.item_value;
      end
      MODE_CLEAR: ledger_fill = 0;
      default: ;
    endcase
    r.occupancy = OCC_W'(ledger_fill);
    return r;
  endfunction

  task automatic add_cmd(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    cmd_beat_t c;
    c.mode       = m;
    c.key        = k;
    c.item_value = v;
    cmd_q.push_back(c);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, N_POOL - 1)];
    return $urandom;
  endfunction

  function automatic logic [MODE_W-1:0] pick_mixed_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return MODE_APPEND;
    if (r < 50) return MODE_REMOVE;
    if (r < 68) return MODE_LOOKUP;
    if (r < 90) return MODE_UPDATE;
    if (r < 95) return MODE_CLEAR;
    return MODE_W'($urandom_range(MODE_CLEAR + 1, {MODE_W{1'b1}}));
  endfunction

  // driver
  always @(posedge clk or negedge rst_n) begin
    cmd_beat_t nxt;
    int        g;
    if (!rst_n) begin
      cmd_bus.valid      <= 1'b0;
      cmd_bus.mode       <= '0;
      cmd_bus.key        <= '0;
      cmd_bus.item_value <= '0;
      tx_gap             <= 0;
      tx_burst           <= 1'b0;
    end else if (cmd_bus.valid) begin
      if (cmd_bus.ready) begin
        expected_rsp_q.push_back(ledger_apply({cmd_bus.mode, cmd_bus.key,
                                               cmd_bus.item_value}));
        if ($urandom_range(0, 31) == 0) tx_burst <= ~tx_burst;
        g = tx_burst ? 0 : $urandom_range(0, 8);
        if (g == 0 && cmd_q.size() != 0) begin
          nxt = cmd_q.pop_front();
          cmd_bus.mode       <= nxt.mode;
          cmd_bus.key        <= nxt.key;
          cmd_bus.item_value <= nxt.item_value;
        end else begin
          cmd_bus.valid <= 1'b0;
          tx_gap        <= g;
        end
      end
    end else if (tx_gap != 0) begin
      tx_gap <= tx_gap - 1;
    end else if (cmd_q.size() != 0) begin
      nxt = cmd_q.pop_front();
      cmd_bus.mode       <= nxt.mode;
      cmd_bus.key        <= nxt.key;
      cmd_bus.item_value <= nxt.item_value;
      cmd_bus.valid      <= 1'b1;
    end
  end

  // monitor and checker
  always @(posedge clk or negedge rst_n) begin
    rsp_beat_t want;
    int        s;
    int        e;
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
      rx_stall      <= 0;
      rx_burst      <= 1'b0;
      hold_done     <= 1'b0;
      rsp_count     <= 0;
      err_count     <= 0;
    end else if (rsp_bus.ready) begin
      if (rsp_bus.valid) begin
        e = 0;
        if (expected_rsp_q.size() == 0) begin
          $error("response beat with no command outstanding");
          e++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_bus.found_value !== want.found_value) begin
            $error("found_value: expected %0d, got %0d", want.found_value,
                   rsp_bus.found_value);
            e++;
          end
          if (rsp_bus.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
            e++;
          end
          if (rsp_bus.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_bus.occupancy);
            e++;
          end
        end
        if (e != 0) err_count <= err_count + e;
        rsp_count <= rsp_count + 1;
        if ($urandom_range(0, 31) == 0) rx_burst <= ~rx_burst;
        s = rx_burst ? 0 : $urandom_range(0, 8);
        // hold off once so the block backs up and stalls its command side
        if (!hold_done && rsp_count == HOLD_AT) begin
          s         = LONG_HOLD;
          hold_done <= 1'b1;
        end
        if (s != 0) begin
          rsp_bus.ready <= 1'b0;
          rx_stall      <= s;
        end
      end
    end else if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [KEY_W-1:0] k;
    int               n;
    int               seg;
    rst_n       = 1'b0;
    ledger_fill = 0;
    for (int i = 0; i < N_POOL; i++) key_pool[i] = $urandom;
    key_pool[0] = {1'b1, {(KEY_W - 1){1'b0}}};
    key_pool[1] = {1'b0, {(KEY_W - 1){1'b1}}};
    k = key_pool[2];

    add_cmd(MODE_LOOKUP, k, '0);
    add_cmd(MODE_REMOVE, k, '0);
    add_cmd(MODE_UPDATE, k, '1);
    add_cmd(MODE_APPEND, key_pool[0], {1'b0, {(VAL_W - 1){1'b1}}});
    add_cmd(MODE_APPEND, key_pool[1], {1'b1, {(VAL_W - 1){1'b0}}});
    add_cmd(MODE_APPEND, '0, '0);
    add_cmd(MODE_APPEND, '1, '1);
    add_cmd(MODE_APPEND, k, 32'h0000_1111);
    add_cmd(MODE_APPEND, k, 32'h0000_2222);
    add_cmd(MODE_LOOKUP, k, '0);
    add_cmd(MODE_UPDATE, k, 32'h5A5A_A5A5);
    add_cmd(MODE_LOOKUP, k, '0);
    add_cmd(MODE_REMOVE, key_pool[0], '0);
    add_cmd(MODE_REMOVE, k, '0);
    add_cmd(MODE_LOOKUP, k, '0);
    add_cmd(MODE_REMOVE, '1, '0);
    add_cmd(MODE_REMOVE, key_pool[3], '0);
    add_cmd(MODE_UPDATE, key_pool[3], '1);
    add_cmd(MODE_W'(MODE_CLEAR + 1), k, '1);
    add_cmd({MODE_W{1'b1}}, '1, '1);
    add_cmd(MODE_CLEAR, k, '1);
    add_cmd(MODE_LOOKUP, key_pool[1], '0);

    seg = 0;
    while (cmd_q.size() < N_ITEMS) begin
      case (seg == 0 ? 0 : $urandom_range(0, 3))
        0: begin
          n = (seg == 0) ? DEPTH + 2 : $urandom_range(8, 20);
          repeat (n) add_cmd(MODE_APPEND, pick_key(), $urandom);
        end
        1: begin
          n = $urandom_range(8, 20);
          repeat (n) add_cmd($urandom_range(0, 4) == 0 ? MODE_LOOKUP : MODE_REMOVE,
                             pick_key(), $urandom);
        end
        default: begin
          n = $urandom_range(10, 30);
          repeat (n) add_cmd(pick_mixed_mode(), pick_key(), $urandom);
        end
      endcase
      seg++;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (cmd_q.size() != 0 || cmd_bus.valid || expected_rsp_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
